// ===== hw/rtl/ifr_pkg.sv =====
// shared types and constants of the imu frame receiver
`default_nettype none

package ifr_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h88;
  localparam logic [7:0] SYNC_SECOND = 8'hAF;

  // payload positions at or beyond this are counted but dropped
  localparam int unsigned BUF_DEPTH = 64;

  // only the first bytes of the payload are ever decoded
  localparam int unsigned STORE_BYTES = 28;
  localparam int unsigned STORE_IDX_W = $clog2(STORE_BYTES);
  localparam int unsigned NUM_WORDS   = STORE_BYTES / 2;
  localparam int unsigned WORD_IDX_W  = $clog2(NUM_WORDS);

  localparam int unsigned IDX_W = 4;
  localparam logic [IDX_W-1:0] FIRST_FIELD = 4'd0;
  localparam logic [IDX_W-1:0] LAST_FIELD  = 4'd12;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SYNC = 2'd1,
    PH_LEN  = 2'd2,
    PH_DATA = 2'd3
  } phase_e;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;
  typedef word_t [NUM_WORDS-1:0] frame_words_t;

  // frame close event handed from parser to emitter
  typedef struct packed {
    logic         valid;
    frame_words_t words;
  } frame_evt_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ifr_parser.sv =====
// byte parser: sync search, length capture and payload store
`default_nettype none

module ifr_parser import ifr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       emit_ready_i,
  output frame_evt_t      frame_evt_o
);

  phase_e phase_q, phase_d;
  logic [7:0] len_q, len_d;
  logic [7:0] count_q, count_d;
  byte_t      store_q [STORE_BYTES];

  logic accept;
  logic at_close;
  logic store_we;

  assign at_close   = (phase_q == PH_DATA) && (count_q == len_q);
  assign in_stall_o = at_close && !emit_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  // next state
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_IDLE: begin
        if (accept && (rx_byte_i == SYNC_FIRST)) phase_d = PH_SYNC;
      end
      PH_SYNC: begin
        if (accept && (rx_byte_i == SYNC_SECOND)) phase_d = PH_LEN;
      end
      PH_LEN: begin
        if (accept) phase_d = PH_DATA;
      end
      PH_DATA: begin
        if (accept && at_close) phase_d = PH_IDLE;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    len_d             = len_q;
    count_d           = count_q;
    store_we          = 1'b0;
    frame_evt_o.valid = 1'b0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      frame_evt_o.words[w] = {store_q[2*w], store_q[2*w+1]};
    end
    case (phase_q)
      PH_LEN: begin
        if (accept) begin
          len_d   = rx_byte_i;
          count_d = 8'd0;
        end
      end
      PH_DATA: begin
        if (accept) begin
          if (at_close) begin
            frame_evt_o.valid = 1'b1;
          end else begin
            count_d  = count_q + 8'd1;
            store_we = ({1'b0, count_q} < 9'(BUF_DEPTH)) &&
                       ({1'b0, count_q} < 9'(STORE_BYTES));
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      len_q   <= 8'd0;
      count_q <= 8'd0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STORE_BYTES; i++) store_q[i] <= 8'd0;
    end else if (store_we) begin
      store_q[count_q[STORE_IDX_W-1:0]] <= rx_byte_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ifr_emitter.sv =====
// frame snapshot, field decode and output register
`default_nettype none

module ifr_emitter import ifr_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire frame_evt_t    frame_evt_i,
  output logic               emit_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [IDX_W-1:0]   field_index_o,
  output logic signed [31:0] field_value_o,
  output logic               last_o
);

  word_t            snap_q [NUM_WORDS];
  logic             pend_q;
  logic [IDX_W-1:0] idx_q;
  logic             out_valid_q;
  logic [IDX_W-1:0] out_index_q;
  logic [31:0]      out_value_q, out_value_d;
  logic             out_last_q;

  logic  load_out;
  word_t cur_word;

  assign emit_ready_o = !pend_q;
  assign load_out     = pend_q && (!out_valid_q || !out_stall_i);
  assign cur_word     = snap_q[idx_q[WORD_IDX_W-1:0]];

  always_comb begin
    if (idx_q == LAST_FIELD) begin
      // pressure, little endian over bytes 24..27
      out_value_d = {snap_q[NUM_WORDS-1][7:0], snap_q[NUM_WORDS-1][15:8],
                     snap_q[NUM_WORDS-2][7:0], snap_q[NUM_WORDS-2][15:8]};
    end else begin
      out_value_d = {{16{cur_word[15]}}, cur_word};
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_evt_i.valid) begin
      for (int w = 0; w < NUM_WORDS; w++) snap_q[w] <= frame_evt_i.words[w];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      idx_q       <= FIRST_FIELD;
      out_valid_q <= 1'b0;
    end else begin
      if (frame_evt_i.valid) begin
        pend_q <= 1'b1;
        idx_q  <= FIRST_FIELD;
      end else if (load_out) begin
        if (idx_q == LAST_FIELD) pend_q <= 1'b0;
        else                     idx_q  <= idx_q + 4'd1;
      end
      if (load_out)          out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_index_q <= idx_q;
      out_value_q <= out_value_d;
      out_last_q  <= (idx_q == LAST_FIELD);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign field_index_o = out_index_q;
  assign field_value_o = out_value_q;
  assign last_o        = out_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/imu_frame_receiver.sv =====
// top level of the imu frame receiver
//
// usage: one received byte enters per input beat (rx_byte_i, in_valid_i / in_stall_o).
// the parser hunts for 0x88, then for 0xaf, takes the next byte as payload length
// and stores the payload; the byte after the payload closes the frame.
// a closing beat snapshots the first 28 payload bytes into the emitter, which
// sends 13 output beats (field_index_o, field_value_o, last_o) one per cycle unless
// out_stall_i holds them: twelve sign extended 16-bit big endian fields, then the
// 32-bit little endian pressure word with last_o set.
// result path: the closing beat loads the snapshot register, from which the first
// result is then loaded into the output register that drives the outputs.
// throughput: one input beat per cycle; in_stall_o rises only on a closing byte
// while the previous frame's results are still being drained, so the 13 result
// beats of one frame and the next frame's bytes overlap freely.
// receiver stall: out_stall_i holds the output register, the snapshot keeps the
// pending results, and the input side keeps taking bytes.
// reset: phase goes idle, length and count clear, the payload store reads as zero
// and no result is pending.

`default_nettype none

module imu_frame_receiver import ifr_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    rx_byte_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [3:0]         field_index_o,
  output logic signed [31:0] field_value_o,
  output logic               last_o
);

  // frame close event with the decoded byte window
  frame_evt_t frame_evt;
  // emitter has no results outstanding
  logic       emit_ready;

  ifr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .emit_ready_i(emit_ready),
    .frame_evt_o (frame_evt)
  );

  ifr_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_evt_i  (frame_evt),
    .emit_ready_o (emit_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .field_index_o(field_index_o),
    .field_value_o(field_value_o),
    .last_o       (last_o)
  );

`ifndef SYNTHESIS
  // last marks the pressure field and nothing else
  a_last_on_pressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (field_index_o == LAST_FIELD)))
    else $error("last flag does not match pressure field");

  // input is held back only while a previous frame is still draining
  a_stall_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> !emit_ready)
    else $error("input stalled with emitter idle");

  // a closing beat always leaves results pending
  a_close_pends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_evt.valid |=> !emit_ready)
    else $error("frame close did not start emission");
`endif

endmodule

`default_nettype wire
